// File: hw/rtl/tpm_rfp_pkg.sv
// tpm_rfp_pkg: types and constants for the tpm response frame parser
// used by tpm_response_frame_parser; depends on nothing else
package tpm_rfp_pkg;

    localparam logic [12:0] MAX_FRAME_BYTES = 13'd512;
    localparam logic [12:0] HDR_BYTES       = 13'd10;
    localparam logic [12:0] SIZE_AT         = 13'd6;
    localparam logic [12:0] LEN_FIELD_AT    = 13'd2;
    localparam logic [5:0]  DIGEST_BYTES    = 6'd32;
    localparam logic [31:0] RC_SUCCESS      = 32'h0000_0000;
    localparam logic [31:0] RC_NONE         = 32'hFFFF_FFFF;

    localparam logic [12:0] CAP_RESET       = 13'd512;

    localparam logic OP_DATA = 1'b0;
    localparam logic OP_END  = 1'b1;

    localparam logic KIND_DIGEST  = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam logic CFG_RSP_CAPACITY   = 1'b0;
    localparam logic CFG_PARSE_PCR_READ = 1'b1;

    localparam logic [7:0] LEN_UPD    = 8'd4;
    localparam logic [7:0] LEN_SELCNT = 8'd4;
    localparam logic [7:0] LEN_HASH   = 8'd2;
    localparam logic [7:0] LEN_SELSZ  = 8'd1;
    localparam logic [7:0] LEN_DIGCNT = 8'd4;
    localparam logic [7:0] LEN_DSZ    = 8'd2;
    localparam logic [7:0] LEN_NONE   = 8'd0;

    typedef enum logic [10:0] {
        PH_HDR     = 11'b000_0000_0001,
        PH_UPD     = 11'b000_0000_0010,
        PH_SELCNT  = 11'b000_0000_0100,
        PH_SELHASH = 11'b000_0000_1000,
        PH_SELSZ   = 11'b000_0001_0000,
        PH_SELMAP  = 11'b000_0010_0000,
        PH_DIGCNT  = 11'b000_0100_0000,
        PH_DSZ     = 11'b000_1000_0000,
        PH_DIGEST  = 11'b001_0000_0000,
        PH_TAIL    = 11'b010_0000_0000,
        PH_DISCARD = 11'b100_0000_0000
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_OVERFLOW  = 3'd1,
        ST_BADSIZE   = 3'd2,
        ST_SHORT     = 3'd3,
        ST_TPMERR    = 3'd4,
        ST_MALFORMED = 3'd5
    } status_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  digest_byte;
        logic [4:0]  digest_index;
        logic [12:0] frame_length;
        logic [31:0] return_code;
        status_t     status;
        logic        last;
    } result_t;

    function automatic result_t make_summary(logic [12:0] len, logic [31:0] rc,
                                             status_t st);
        result_t r;
        r.kind         = KIND_SUMMARY;
        r.digest_byte  = 8'd0;
        r.digest_index = 5'd0;
        r.frame_length = len;
        r.return_code  = (len < HDR_BYTES) ? RC_NONE : rc;
        r.status       = st;
        r.last         = 1'b1;
        return r;
    endfunction

    function automatic result_t make_digest(logic [7:0] b, logic [4:0] idx);
        result_t r;
        r.kind         = KIND_DIGEST;
        r.digest_byte  = b;
        r.digest_index = idx;
        r.frame_length = 13'd0;
        r.return_code  = RC_SUCCESS;
        r.status       = ST_OK;
        r.last         = 1'b1;
        return r;
    endfunction

endpackage

// File: hw/rtl/tpm_response_frame_parser.sv
// tpm_response_frame_parser: walks tpm 2.0 response bytes, streams the pcr digest
// and emits one summary word per frame; depends on tpm_rfp_pkg
//
//  channel   | direction | signals                                  | word
//  s_axis    | in        | s_axis_tvalid/tready/tdata/tuser         | response byte or end event
//  m_axis    | out       | m_axis_tvalid/tready/tdata/tuser/tlast   | digest byte or summary
//  cfg       | in        | cfg_valid/ready/index/data               | register write
//
// one input word per cycle while two queue slots are free; header, body walk and summary
// are decided in the same cycle the word is taken and land in a 4-entry result queue
// a word that gives a digest byte and the summary together fills two queue slots,
// so the input takes a new word only while two slots are free
// output stalls hold words in the queue; the input stops while fewer than two slots are free
// reset clears the queue and the parser state, capacity 512, pcr mode on
// cfg is always ready and takes effect for the next word
module tpm_response_frame_parser
    import tpm_rfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] digest_byte, [12:8] digest_index, [25:13] frame_length,
    // [57:26] return_code, [60:58] status, [63:61] zero
    output logic [63:0] m_axis_tdata,
    output logic        m_axis_tuser,   // [0] kind
    output logic        m_axis_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [12:0] cfg_data
);

    localparam int          QDEPTH = 4;
    localparam logic [2:0]  QROOM  = 3'(QDEPTH - 2);
    localparam logic [2:0]  QFULL  = 3'(QDEPTH);

    logic [12:0] rsp_capacity_reg;
    logic        parse_pcr_read_reg;

    phase_t      phase_reg, phase_next;
    logic [12:0] byte_count_reg, byte_count_next;
    logic [12:0] frame_size_reg, frame_size_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] rc_reg, rc_next;
    logic [31:0] sel_reg, sel_next;
    logic [7:0]  skip_reg, skip_next;
    logic [5:0]  dpos_reg, dpos_next;
    logic        body_bad_reg, body_bad_next;

    result_t     q_mem_reg [QDEPTH];
    logic [1:0]  wr_ptr_reg, wr_ptr_next;
    logic [1:0]  rd_ptr_reg, rd_ptr_next;
    logic [2:0]  count_reg, count_next;

    logic        in_fire, out_fire;
    logic [12:0] cap;
    logic [31:0] acc_sh;
    logic [12:0] bc_inc;
    logic [7:0]  skip_dec;
    logic [31:0] sel_dec;
    logic [5:0]  dpos_inc;
    logic        dig_emit, sum_emit, clear;
    status_t     sum_st;
    result_t     dig_res, sum_res, push_a, push_b;
    logic [1:0]  n_push;

    assign cfg_ready     = 1'b1;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_fire      = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (count_reg <= QROOM);

    assign cap      = (rsp_capacity_reg < MAX_FRAME_BYTES) ? rsp_capacity_reg
                                                           : MAX_FRAME_BYTES;
    assign acc_sh   = {acc_reg[23:0], s_axis_tdata};
    assign bc_inc   = byte_count_reg + 13'd1;
    assign skip_dec = skip_reg - 8'd1;
    assign sel_dec  = sel_reg - 32'd1;
    assign dpos_inc = dpos_reg + 6'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_capacity_reg   <= CAP_RESET;
            parse_pcr_read_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_RSP_CAPACITY:   rsp_capacity_reg   <= cfg_data;
                CFG_PARSE_PCR_READ: parse_pcr_read_reg <= cfg_data[0];
                default:            rsp_capacity_reg   <= rsp_capacity_reg;
            endcase
        end
    end

    always_comb
    begin
        phase_next      = phase_reg;
        byte_count_next = byte_count_reg;
        frame_size_next = frame_size_reg;
        acc_next        = acc_reg;
        rc_next         = rc_reg;
        sel_next        = sel_reg;
        skip_next       = skip_reg;
        dpos_next       = dpos_reg;
        body_bad_next   = body_bad_reg;
        dig_emit        = 1'b0;
        sum_emit        = 1'b0;
        clear           = 1'b0;
        sum_st          = ST_OK;

        if (in_fire)
        begin
            if (s_axis_tuser == OP_END)
            begin
                if (phase_reg != PH_DISCARD)
                begin
                    sum_emit = 1'b1;
                    sum_st   = ST_SHORT;
                end
                clear = 1'b1;
            end
            else if (phase_reg != PH_DISCARD)
            begin
                if (byte_count_reg >= cap)
                begin
                    sum_emit   = 1'b1;
                    sum_st     = ST_OVERFLOW;
                    phase_next = PH_DISCARD;
                end
                else
                begin
                    byte_count_next = bc_inc;
                    unique case (phase_reg)
                        PH_HDR:
                        begin
                            if (byte_count_reg >= LEN_FIELD_AT && byte_count_reg < SIZE_AT)
                                acc_next = acc_sh;
                            else if (byte_count_reg >= SIZE_AT)
                                rc_next = {rc_reg[23:0], s_axis_tdata};
                            if (bc_inc == SIZE_AT)
                            begin
                                if (acc_next < {19'd0, HDR_BYTES} || acc_next > {19'd0, cap})
                                begin
                                    sum_emit   = 1'b1;
                                    sum_st     = ST_BADSIZE;
                                    phase_next = PH_DISCARD;
                                end
                                else
                                    frame_size_next = acc_next[12:0];
                            end
                            if (bc_inc == HDR_BYTES)
                            begin
                                phase_next = PH_UPD;
                                skip_next  = LEN_UPD;
                                acc_next   = 32'd0;
                            end
                        end
                        PH_UPD:
                        begin
                            skip_next = skip_dec;
                            if (skip_dec == 8'd0)
                            begin
                                phase_next = PH_SELCNT;
                                skip_next  = LEN_SELCNT;
                                acc_next   = 32'd0;
                            end
                        end
                        PH_SELCNT:
                        begin
                            acc_next  = acc_sh;
                            skip_next = skip_dec;
                            if (skip_dec == 8'd0)
                            begin
                                sel_next   = acc_sh;
                                acc_next   = 32'd0;
                                phase_next = (acc_sh == 32'd0) ? PH_DIGCNT : PH_SELHASH;
                                skip_next  = (acc_sh == 32'd0) ? LEN_DIGCNT : LEN_HASH;
                            end
                        end
                        PH_SELHASH:
                        begin
                            skip_next = skip_dec;
                            if (skip_dec == 8'd0)
                            begin
                                phase_next = PH_SELSZ;
                                skip_next  = LEN_SELSZ;
                                acc_next   = 32'd0;
                            end
                        end
                        PH_SELSZ:
                        begin
                            acc_next = 32'd0;
                            if (s_axis_tdata == 8'd0)
                            begin
                                sel_next   = sel_dec;
                                phase_next = (sel_dec == 32'd0) ? PH_DIGCNT : PH_SELHASH;
                                skip_next  = (sel_dec == 32'd0) ? LEN_DIGCNT : LEN_HASH;
                            end
                            else
                            begin
                                phase_next = PH_SELMAP;
                                skip_next  = s_axis_tdata;
                            end
                        end
                        PH_SELMAP:
                        begin
                            skip_next = skip_dec;
                            if (skip_dec == 8'd0)
                            begin
                                sel_next   = sel_dec;
                                acc_next   = 32'd0;
                                phase_next = (sel_dec == 32'd0) ? PH_DIGCNT : PH_SELHASH;
                                skip_next  = (sel_dec == 32'd0) ? LEN_DIGCNT : LEN_HASH;
                            end
                        end
                        PH_DIGCNT:
                        begin
                            acc_next  = acc_sh;
                            skip_next = skip_dec;
                            if (skip_dec == 8'd0)
                            begin
                                acc_next = 32'd0;
                                if (acc_sh == 32'd0)
                                begin
                                    body_bad_next = 1'b1;
                                    phase_next    = PH_TAIL;
                                    skip_next     = LEN_NONE;
                                end
                                else
                                begin
                                    phase_next = PH_DSZ;
                                    skip_next  = LEN_DSZ;
                                end
                            end
                        end
                        PH_DSZ:
                        begin
                            acc_next  = acc_sh;
                            skip_next = skip_dec;
                            if (skip_dec == 8'd0)
                            begin
                                acc_next  = 32'd0;
                                skip_next = LEN_NONE;
                                if (acc_sh != {26'd0, DIGEST_BYTES})
                                begin
                                    body_bad_next = 1'b1;
                                    phase_next    = PH_TAIL;
                                end
                                else
                                begin
                                    phase_next = PH_DIGEST;
                                    dpos_next  = 6'd0;
                                end
                            end
                        end
                        PH_DIGEST:
                        begin
                            dig_emit  = parse_pcr_read_reg && (rc_reg == RC_SUCCESS);
                            dpos_next = dpos_inc;
                            if (dpos_inc >= DIGEST_BYTES)
                            begin
                                phase_next = PH_TAIL;
                                skip_next  = LEN_NONE;
                                acc_next   = 32'd0;
                            end
                        end
                        default:
                        begin
                            phase_next = phase_reg;
                        end
                    endcase

                    // frame complete
                    if (!sum_emit && bc_inc >= SIZE_AT && bc_inc == frame_size_next)
                    begin
                        sum_emit = 1'b1;
                        clear    = 1'b1;
                        if (rc_next != RC_SUCCESS)
                            sum_st = ST_TPMERR;
                        else if (parse_pcr_read_reg &&
                                 !(phase_next == PH_TAIL && !body_bad_next))
                            sum_st = ST_MALFORMED;
                        else
                            sum_st = ST_OK;
                    end
                end
            end
        end

        dig_res = make_digest(s_axis_tdata, dpos_reg[4:0]);
        sum_res = make_summary(byte_count_next, rc_next, sum_st);

        if (clear)
        begin
            phase_next      = PH_HDR;
            byte_count_next = 13'd0;
            frame_size_next = HDR_BYTES;
            acc_next        = 32'd0;
            rc_next         = RC_SUCCESS;
            sel_next        = 32'd0;
            skip_next       = LEN_NONE;
            dpos_next       = 6'd0;
            body_bad_next   = 1'b0;
        end
    end

    // queue push, digest ahead of summary
    always_comb
    begin
        push_a = dig_emit ? dig_res : sum_res;
        push_b = sum_res;
        if (dig_emit && sum_emit)
            push_a.last = 1'b0;
        n_push = {1'b0, dig_emit} + {1'b0, sum_emit};
    end

    assign wr_ptr_next = wr_ptr_reg + n_push;
    assign rd_ptr_next = out_fire ? rd_ptr_reg + 2'd1 : rd_ptr_reg;
    assign count_next  = count_reg + {1'b0, n_push} - {2'd0, out_fire};

    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
            q_mem_reg[wr_ptr_reg] <= push_a;
        if (n_push == 2'd2)
            q_mem_reg[wr_ptr_reg + 2'd1] <= push_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HDR;
            byte_count_reg <= 13'd0;
            frame_size_reg <= HDR_BYTES;
            acc_reg        <= 32'd0;
            rc_reg         <= RC_SUCCESS;
            sel_reg        <= 32'd0;
            skip_reg       <= LEN_NONE;
            dpos_reg       <= 6'd0;
            body_bad_reg   <= 1'b0;
            wr_ptr_reg     <= 2'd0;
            rd_ptr_reg     <= 2'd0;
            count_reg      <= 3'd0;
        end
        else
        begin
            phase_reg      <= phase_next;
            byte_count_reg <= byte_count_next;
            frame_size_reg <= frame_size_next;
            acc_reg        <= acc_next;
            rc_reg         <= rc_next;
            sel_reg        <= sel_next;
            skip_reg       <= skip_next;
            dpos_reg       <= dpos_next;
            body_bad_reg   <= body_bad_next;
            wr_ptr_reg     <= wr_ptr_next;
            rd_ptr_reg     <= rd_ptr_next;
            count_reg      <= count_next;
        end
    end

    assign m_axis_tvalid = (count_reg != 3'd0);
    assign m_axis_tuser  = q_mem_reg[rd_ptr_reg].kind;
    assign m_axis_tlast  = q_mem_reg[rd_ptr_reg].last;
    assign m_axis_tdata  = {3'd0,
                            q_mem_reg[rd_ptr_reg].status,
                            q_mem_reg[rd_ptr_reg].return_code,
                            q_mem_reg[rd_ptr_reg].frame_length,
                            q_mem_reg[rd_ptr_reg].digest_index,
                            q_mem_reg[rd_ptr_reg].digest_byte};

`ifndef ASSERT_OFF
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QFULL)
        else $error("result queue over depth");

    a_ready_room: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> count_reg <= QROOM)
        else $error("input ready without room for two words");

    a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_SUMMARY |-> m_axis_tlast)
        else $error("summary word without tlast");

    a_digest_pos: assert property (@(posedge clk) disable iff (!rst_n)
        dpos_reg <= DIGEST_BYTES)
        else $error("digest position past digest end");

    a_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && s_axis_tuser == OP_END |=> byte_count_reg == 13'd0 && phase_reg == PH_HDR)
        else $error("end of data did not restart the frame");
`endif

endmodule
